/* design/cfr_pkg.sv */
// Shared types, character constants and the microprogram of the console format renderer.
// Used by the sequencer, the datapath and the top level; depends on nothing.

package cfr_pkg;

  // Microprogram step addresses
  typedef logic [3:0] upc_t;
  localparam upc_t ST_IDLE  = 4'd0;
  localparam upc_t ST_TR_NL = 4'd1;
  localparam upc_t ST_TR_BS = 4'd2;
  localparam upc_t ST_CR    = 4'd3;
  localparam upc_t ST_CHAR  = 4'd4;
  localparam upc_t ST_BS    = 4'd5;
  localparam upc_t ST_SP    = 4'd6;
  localparam upc_t ST_HEX   = 4'd7;
  localparam upc_t ST_DSIGN = 4'd8;
  localparam upc_t ST_MINUS = 4'd9;
  localparam upc_t ST_DMUL  = 4'd10;
  localparam upc_t ST_DDIV  = 4'd11;
  localparam upc_t ST_DOUT  = 4'd12;

  // Byte sources for an emit step
  typedef logic [2:0] src_t;
  localparam src_t SRC_CHAR  = 3'd0;
  localparam src_t SRC_CR    = 3'd1;
  localparam src_t SRC_SP    = 3'd2;
  localparam src_t SRC_HEX   = 3'd3;
  localparam src_t SRC_MINUS = 3'd4;
  localparam src_t SRC_DIGIT = 3'd5;

  // Datapath operations
  typedef logic [2:0] dpop_t;
  localparam dpop_t OP_NOP  = 3'd0;
  localparam dpop_t OP_LDF  = 3'd1;
  localparam dpop_t OP_LDA  = 3'd2;
  localparam dpop_t OP_LDV  = 3'd3;
  localparam dpop_t OP_SHL4 = 3'd4;
  localparam dpop_t OP_NEG  = 3'd5;
  localparam dpop_t OP_MUL  = 3'd6;
  localparam dpop_t OP_PUSH = 3'd7;

  // Jump conditions
  typedef logic [2:0] cond_t;
  localparam cond_t CND_ALWAYS  = 3'd0;
  localparam cond_t CND_NL      = 3'd1;
  localparam cond_t CND_BS      = 3'd2;
  localparam cond_t CND_HEXEND  = 3'd3;
  localparam cond_t CND_NEG     = 3'd4;
  localparam cond_t CND_QZERO   = 3'd5;
  localparam cond_t CND_LASTDIG = 3'd6;

  // How the last-byte flag is set on an emit step
  typedef logic [1:0] lastm_t;
  localparam lastm_t LST_NO   = 2'd0;
  localparam lastm_t LST_YES  = 2'd1;
  localparam lastm_t LST_COND = 2'd2;

  // Character codes
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LC_C  = 8'h63;
  localparam logic [7:0] CH_LC_D  = 8'h64;
  localparam logic [7:0] CH_LC_X  = 8'h78;

  localparam logic [7:0] HEX_TAB [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
  };

  // Decimal conversion: q = (x * RECIP) >> RECIP_SHIFT is x / 10 for any 32-bit x
  localparam logic [31:0] RECIP       = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;
  localparam int          Q_W         = 64 - RECIP_SHIFT;
  localparam logic [3:0]  DIG_MAX     = 4'd10;
  localparam logic [2:0]  NIB_LAST    = 3'd7;

  typedef struct packed {
    logic   dispatch;
    logic   emit;
    src_t   src;
    lastm_t last;
    dpop_t  op;
    cond_t  cond;
    upc_t   jt;
    upc_t   jf;
  } uword_t;

  typedef struct packed {
    logic  emit;
    src_t  src;
    logic  last;
    dpop_t op;
  } ctrl_t;

  typedef struct packed {
    logic is_nl;
    logic is_bs;
    logic hex_end;
    logic neg;
    logic q_zero;
    logic last_dig;
    logic out_free;
  } stat_t;

  function automatic uword_t mk_uw(input logic disp, input logic emit, input src_t src,
                                   input lastm_t lm, input dpop_t op, input cond_t cnd,
                                   input upc_t jt, input upc_t jf);
    uword_t w;
    w.dispatch = disp;
    w.emit     = emit;
    w.src      = src;
    w.last     = lm;
    w.op       = op;
    w.cond     = cnd;
    w.jt       = jt;
    w.jf       = jf;
    return w;
  endfunction

  // Microprogram ROM; a true condition takes jt, a false one jf
  function automatic uword_t ucode_rom(input upc_t pc);
    uword_t w;
    case (pc)
      ST_IDLE:  w = mk_uw(1'b1, 1'b0, SRC_CHAR,  LST_NO,   OP_NOP,  CND_ALWAYS,  ST_IDLE, ST_IDLE);
      ST_TR_NL: w = mk_uw(1'b0, 1'b0, SRC_CHAR,  LST_NO,   OP_NOP,  CND_NL,      ST_CR,   ST_TR_BS);
      ST_TR_BS: w = mk_uw(1'b0, 1'b0, SRC_CHAR,  LST_NO,   OP_NOP,  CND_BS,      ST_BS,   ST_CHAR);
      ST_CR:    w = mk_uw(1'b0, 1'b1, SRC_CR,    LST_NO,   OP_NOP,  CND_ALWAYS,  ST_CHAR, ST_CHAR);
      ST_CHAR:  w = mk_uw(1'b0, 1'b1, SRC_CHAR,  LST_YES,  OP_NOP,  CND_ALWAYS,  ST_IDLE, ST_IDLE);
      ST_BS:    w = mk_uw(1'b0, 1'b1, SRC_CHAR,  LST_NO,   OP_NOP,  CND_ALWAYS,  ST_SP,   ST_SP);
      ST_SP:    w = mk_uw(1'b0, 1'b1, SRC_SP,    LST_NO,   OP_NOP,  CND_ALWAYS,  ST_CHAR, ST_CHAR);
      ST_HEX:   w = mk_uw(1'b0, 1'b1, SRC_HEX,   LST_COND, OP_SHL4, CND_HEXEND,  ST_IDLE, ST_HEX);
      ST_DSIGN: w = mk_uw(1'b0, 1'b0, SRC_CHAR,  LST_NO,   OP_NOP,  CND_NEG,     ST_MINUS, ST_DMUL);
      ST_MINUS: w = mk_uw(1'b0, 1'b1, SRC_MINUS, LST_NO,   OP_NEG,  CND_ALWAYS,  ST_DMUL, ST_DMUL);
      ST_DMUL:  w = mk_uw(1'b0, 1'b0, SRC_CHAR,  LST_NO,   OP_MUL,  CND_ALWAYS,  ST_DDIV, ST_DDIV);
      ST_DDIV:  w = mk_uw(1'b0, 1'b0, SRC_CHAR,  LST_NO,   OP_PUSH, CND_QZERO,   ST_DOUT, ST_DMUL);
      ST_DOUT:  w = mk_uw(1'b0, 1'b1, SRC_DIGIT, LST_COND, OP_NOP,  CND_LASTDIG, ST_IDLE, ST_DOUT);
      default:  w = mk_uw(1'b0, 1'b0, SRC_CHAR,  LST_NO,   OP_NOP,  CND_ALWAYS,  ST_IDLE, ST_IDLE);
    endcase
    return w;
  endfunction

endpackage

/* design/cfr_in_if.sv */
// Input channel of the console format renderer: one format byte and its argument word.
// Standalone; no package needed.

interface cfr_in_if;
  logic               valid;
  logic               ready;
  logic [7:0]         fmt_char;
  logic signed [31:0] arg_value;

  modport source (output valid, output fmt_char, output arg_value, input ready);
  modport sink   (input valid, input fmt_char, input arg_value, output ready);
endinterface

/* design/cfr_out_if.sv */
// Result channel of the console format renderer: one terminal byte and its last flag.
// Standalone; no package needed.

interface cfr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       run_last;

  modport source (output valid, output out_char, output run_last, input ready);
  modport sink   (input valid, input out_char, input run_last, output ready);
endinterface

/* design/cfr_seq.sv */
// Microcode sequencer: step counter, ROM lookup, jump selection, item dispatch.
// Depends on cfr_pkg for the control word, the ROM and the character codes.

module cfr_seq import cfr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_fmt,
  input  stat_t      st,
  output ctrl_t      ctrl
);

  upc_t   pc_r, pc_nxt;
  logic   pend_r, pend_nxt;
  uword_t w;
  logic   cond_val;
  logic   go;
  dpop_t  op;

  always_comb begin
    w = ucode_rom(pc_r);
    case (w.cond)
      CND_ALWAYS:  cond_val = 1'b1;
      CND_NL:      cond_val = st.is_nl;
      CND_BS:      cond_val = st.is_bs;
      CND_HEXEND:  cond_val = st.hex_end;
      CND_NEG:     cond_val = st.neg;
      CND_QZERO:   cond_val = st.q_zero;
      CND_LASTDIG: cond_val = st.last_dig;
      default:     cond_val = 1'b1;
    endcase

    // an emit step holds while the output register holds an item that is not taken
    go       = w.dispatch ? in_valid : (!w.emit || st.out_free);
    pc_nxt   = pc_r;
    pend_nxt = pend_r;
    op       = OP_NOP;

    if (w.dispatch) begin
      if (in_valid) begin
        pend_nxt = 1'b0;
        if (in_fmt == CH_NUL) begin
          pc_nxt = ST_IDLE;
        end else if (pend_r) begin
          case (in_fmt)
            CH_LC_C: begin
              op     = OP_LDA;
              pc_nxt = ST_TR_NL;
            end
            CH_LC_X: begin
              op     = OP_LDV;
              pc_nxt = ST_HEX;
            end
            CH_LC_D: begin
              op     = OP_LDV;
              pc_nxt = ST_DSIGN;
            end
            default: pc_nxt = ST_IDLE;
          endcase
        end else if (in_fmt == CH_PCT) begin
          pend_nxt = 1'b1;
        end else begin
          op     = OP_LDF;
          pc_nxt = ST_TR_NL;
        end
      end
    end else if (go) begin
      pc_nxt = cond_val ? w.jt : w.jf;
      op     = w.op;
    end

    ctrl.emit = w.emit && go && !w.dispatch;
    ctrl.src  = w.src;
    ctrl.op   = op;
    case (w.last)
      LST_YES:  ctrl.last = 1'b1;
      LST_COND: ctrl.last = cond_val;
      default:  ctrl.last = 1'b0;
    endcase
  end

  assign in_ready = w.dispatch;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= ST_IDLE;
      pend_r <= 1'b0;
    end else begin
      pc_r   <= pc_nxt;
      pend_r <= pend_nxt;
    end
  end

endmodule

/* design/cfr_dp.sv */
// Datapath: byte register, value shifter, reciprocal divider, digit stack, output register.
// Depends on cfr_pkg for control and status structs, op codes and constants.

module cfr_dp import cfr_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  ctrl_t              ctrl,
  input  logic [7:0]         in_fmt,
  input  logic signed [31:0] in_arg,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [7:0]         out_char,
  output logic               out_last,
  output stat_t              st
);

  logic [7:0]     ch_r, ch_nxt;
  logic [31:0]    val_r, val_nxt;
  logic [Q_W-1:0] q_r, q_nxt;
  logic [3:0]     stk_r [DIG_MAX];
  logic [3:0]     stk_nxt [DIG_MAX];
  logic [3:0]     cnt_r, cnt_nxt;
  logic [2:0]     nib_r, nib_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [7:0]     out_char_r;
  logic           out_last_r;
  logic [63:0]    prod;
  logic [31:0]    q10;
  logic [31:0]    rem_w;
  logic [7:0]     byte_sel;
  logic           pop;

  assign prod  = {32'h0, val_r} * {32'h0, RECIP};
  assign q10   = {q_r, 3'b000} + {2'b00, q_r, 1'b0};
  assign rem_w = val_r - q10;
  assign pop   = ctrl.emit && (ctrl.src == SRC_DIGIT);

  always_comb begin
    case (ctrl.src)
      SRC_CHAR:  byte_sel = ch_r;
      SRC_CR:    byte_sel = CH_CR;
      SRC_SP:    byte_sel = CH_SP;
      SRC_HEX:   byte_sel = HEX_TAB[val_r[31:28]];
      SRC_MINUS: byte_sel = CH_MINUS;
      SRC_DIGIT: byte_sel = CH_ZERO | {4'h0, stk_r[0]};
      default:   byte_sel = ch_r;
    endcase
  end

  always_comb begin
    ch_nxt  = ch_r;
    val_nxt = val_r;
    q_nxt   = q_r;
    stk_nxt = stk_r;
    cnt_nxt = cnt_r;
    nib_nxt = nib_r;
    case (ctrl.op)
      OP_LDF: ch_nxt = in_fmt;
      OP_LDA: ch_nxt = in_arg[7:0];
      OP_LDV: begin
        val_nxt = unsigned'(in_arg);
        cnt_nxt = '0;
        nib_nxt = '0;
      end
      OP_SHL4: begin
        val_nxt = {val_r[27:0], 4'h0};
        nib_nxt = nib_r + 3'd1;
      end
      OP_NEG:  val_nxt = 32'd0 - val_r;
      OP_MUL:  q_nxt = prod[63:RECIP_SHIFT];
      OP_PUSH: begin
        // push the low digit, keep the quotient for the next round
        stk_nxt[0] = rem_w[3:0];
        for (int i = 1; i < DIG_MAX; i++) stk_nxt[i] = stk_r[i-1];
        val_nxt = {{(32-Q_W){1'b0}}, q_r};
        cnt_nxt = cnt_r + 4'd1;
      end
      default: ;
    endcase
    if (pop) begin
      for (int i = 0; i < DIG_MAX - 1; i++) stk_nxt[i] = stk_r[i+1];
      stk_nxt[DIG_MAX-1] = 4'h0;
      cnt_nxt = cnt_r - 4'd1;
    end
  end

  always_comb begin
    if (ctrl.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      nib_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      nib_r       <= nib_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ch_r  <= ch_nxt;
    val_r <= val_nxt;
    q_r   <= q_nxt;
    stk_r <= stk_nxt;
    if (ctrl.emit) begin
      out_char_r <= byte_sel;
      out_last_r <= ctrl.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;

  assign st.is_nl    = (ch_r == CH_NL);
  assign st.is_bs    = (ch_r == CH_BS);
  assign st.hex_end  = (nib_r == NIB_LAST);
  assign st.neg      = val_r[31];
  assign st.q_zero   = (q_r == '0);
  assign st.last_dig = (cnt_r == 4'd1);
  assign st.out_free = !out_valid_r || out_ready;

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= DIG_MAX)
    else $error("digit stack count out of range");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> cnt_r != 4'd0)
    else $error("digit popped from empty stack");

  a_push_ok: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.op == OP_PUSH |-> (rem_w < 32'd10) && (cnt_r < DIG_MAX))
    else $error("bad remainder or stack overflow on digit push");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.emit |-> (!out_valid_r || out_ready))
    else $error("byte emitted over an untaken item");
`endif

endmodule

/* design/console_format_renderer.sv */
// Top level of the console format renderer: microcode sequencer plus datapath.
// Depends on cfr_pkg, cfr_in_if, cfr_out_if, cfr_seq and cfr_dp.
//
//   channel  | direction | payload                          | handshake
//   in_ch    | sink      | fmt_char[7:0], arg_value[31:0] s | valid/ready
//   out_ch   | source    | out_char[7:0], run_last          | valid/ready
//
// One item at a time: an item is taken in the idle step, then its bytes follow.
// Echo or %c: a newline goes out as CR, newline, a backspace as backspace, space,
// backspace; %x: eight hex digits; %d: a minus if negative, then the digits found
// through the shared reciprocal multiplier, pushed on a stack and sent from the top.
// Reset (synchronous, rst_n low) clears the pending flag and returns to the idle step.
// An emit step holds while the output register holds an item that is not taken.

module console_format_renderer import cfr_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  cfr_in_if.sink   in_ch,
  cfr_out_if.source out_ch
);

  ctrl_t ctrl;
  stat_t st;

  cfr_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_fmt   (in_ch.fmt_char),
    .st       (st),
    .ctrl     (ctrl)
  );

  cfr_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .in_fmt    (in_ch.fmt_char),
    .in_arg    (in_ch.arg_value),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_char  (out_ch.out_char),
    .out_last  (out_ch.run_last),
    .st        (st)
  );

endmodule
